// ----- src/srbc_pkg.sv -----
package srbc_pkg;

    // Width of the image height register and of the reported clear rows.
    localparam int HEIGHT_W = 11;
    localparam int CLEAR_W = 11;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd1024;

    // The cutoff row sits this many rows above the image bottom.
    localparam int CUTOFF_MARGIN = 24;

    // Run counter saturates here, meaning two or more runs.
    localparam logic [1:0] RUN_CNT_MAX = 2'd2;
    localparam logic [1:0] RUN_CNT_ONE = 2'd1;

    // Per-row control shared by both lanes.
    typedef struct packed {
        logic take;       // a row transfer happens this cycle
        logic active;     // row index is still inside the tracked range
        logic below_cut;  // current row starts above the cutoff
        logic restart;    // last row of the image: report and start over
    } lane_ctrl_t;

    // What one lane reports for the last row.
    typedef struct packed {
        logic                 clear_enable;
        logic [CLEAR_W-1:0]   clear_from;
    } lane_result_t;

endpackage

// ----- src/srbc_lane.sv -----
module srbc_lane #(
    parameter int COL_BITS = 12,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  srbc_pkg::lane_ctrl_t                  ctrl,
    input  logic [$clog2(MAX_ROWS)-1:0]           row,
    input  logic signed [COL_BITS:0]              span_start,
    input  logic signed [COL_BITS:0]              span_end,
    output srbc_pkg::lane_result_t                result
);

    localparam int RUN_W = $clog2(MAX_ROWS);
    localparam int SPAN_W = COL_BITS + 1;

    logic signed [SPAN_W-1:0] prev_start_reg, prev_start_next;
    logic signed [SPAN_W-1:0] prev_end_reg, prev_end_next;
    logic [1:0]               run_cnt_reg, run_cnt_next;
    logic [RUN_W-1:0]         first_end_reg, first_end_next;
    logic [RUN_W-1:0]         chosen_end_reg, chosen_end_next;
    logic                     chosen_cur_reg, chosen_cur_next;
    logic                     have_chosen_reg, have_chosen_next;

    logic                          span_empty;
    logic                          prev_ok;
    logic                          overlap;
    logic [RUN_W-1:0]              pick_end;
    logic [srbc_pkg::CLEAR_W-1:0]  clear_sum;

    assign span_empty = (span_start < 0) || (span_end < 0);
    assign prev_ok    = (prev_start_reg >= 0) && (prev_end_reg >= 0);
    assign overlap    = prev_ok && !((span_end < prev_start_reg) ||
                                     (span_start > prev_end_reg));

    // Next state with the current row folded in; the report for the last row
    // is taken from these values.
    always_comb
    begin
        prev_start_next  = prev_start_reg;
        prev_end_next    = prev_end_reg;
        run_cnt_next     = run_cnt_reg;
        first_end_next   = first_end_reg;
        chosen_end_next  = chosen_end_reg;
        chosen_cur_next  = chosen_cur_reg;
        have_chosen_next = have_chosen_reg;
        if (ctrl.active)
        begin
            if (span_empty)
            begin
                prev_start_next = '1;
                prev_end_next   = '1;
            end
            else
            begin
                if (overlap)
                begin
                    if (run_cnt_reg == srbc_pkg::RUN_CNT_ONE)
                        first_end_next = row;
                    if (chosen_cur_reg)
                        chosen_end_next = row;
                end
                else
                begin
                    if (run_cnt_reg != srbc_pkg::RUN_CNT_MAX)
                        run_cnt_next = run_cnt_reg + 2'd1;
                    if (run_cnt_next == srbc_pkg::RUN_CNT_ONE)
                        first_end_next = row;
                    if (ctrl.below_cut)
                    begin
                        have_chosen_next = 1'b1;
                        chosen_cur_next  = 1'b1;
                        chosen_end_next  = row;
                    end
                    else
                    begin
                        chosen_cur_next = 1'b0;
                    end
                end
                prev_start_next = span_start;
                prev_end_next   = span_end;
            end
        end
    end

    assign pick_end  = have_chosen_next ? chosen_end_next : first_end_next;
    assign clear_sum = srbc_pkg::CLEAR_W'(pick_end) + srbc_pkg::CLEAR_W'(1);

    always_comb
    begin
        result.clear_enable = (run_cnt_next == srbc_pkg::RUN_CNT_MAX);
        result.clear_from   = result.clear_enable ? clear_sum : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_start_reg  <= '1;
            prev_end_reg    <= '1;
            run_cnt_reg     <= '0;
            first_end_reg   <= '0;
            chosen_end_reg  <= '0;
            chosen_cur_reg  <= 1'b0;
            have_chosen_reg <= 1'b0;
        end
        else if (ctrl.take)
        begin
            if (ctrl.restart)
            begin
                prev_start_reg  <= '1;
                prev_end_reg    <= '1;
                run_cnt_reg     <= '0;
                first_end_reg   <= '0;
                chosen_end_reg  <= '0;
                chosen_cur_reg  <= 1'b0;
                have_chosen_reg <= 1'b0;
            end
            else
            begin
                prev_start_reg  <= prev_start_next;
                prev_end_reg    <= prev_end_next;
                run_cnt_reg     <= run_cnt_next;
                first_end_reg   <= first_end_next;
                chosen_end_reg  <= chosen_end_next;
                chosen_cur_reg  <= chosen_cur_next;
                have_chosen_reg <= have_chosen_next;
            end
        end
    end

endmodule

// ----- src/srbc_merge.sv -----
module srbc_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  srbc_pkg::lane_result_t left_result,
    input  srbc_pkg::lane_result_t right_result,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   left_clear_enable,
    output logic [srbc_pkg::CLEAR_W-1:0] left_clear_from,
    output logic                   right_clear_enable,
    output logic [srbc_pkg::CLEAR_W-1:0] right_clear_from
);

    logic                   valid_reg, valid_next;
    srbc_pkg::lane_result_t left_reg;
    srbc_pkg::lane_result_t right_reg;

    // A new report may load in the same cycle the previous one transfers out.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= left_result;
            right_reg <= right_result;
        end
    end

    assign out_valid          = valid_reg;
    assign left_clear_enable  = left_reg.clear_enable;
    assign left_clear_from    = left_reg.clear_from;
    assign right_clear_enable = right_reg.clear_enable;
    assign right_clear_from   = right_reg.clear_from;

endmodule

// ----- src/span_run_bottom_cutoff.sv -----
// Row span run tracker with bottom cutoff.
//
// Input channel (in_valid/in_ready): one image row per transfer with a left
// and a right column span; a negative end marks an empty span. last_row marks
// the final row of the image. Output channel (out_valid/out_ready): one
// report per image, carrying per side the clear enable and the first row to
// clear. Configuration channel (cfg_valid/cfg_ready, cfg_data): writes the
// image height; cfg_ready is always high. Write it only while the block is idle.
//
// Throughput: one row per cycle. Both sides are handled by their own lane in
// the same cycle, so each row costs one compare pass per side.
// The report is registered and appears in the cycle after the last row's transfer.
// Rows that are not the last are taken even while a report waits at the
// output; a last row waits for the output register to free up, so a stalled
// receiver holds off only the next image's last row.
// Reset clears all run state, empties the output register and sets the image
// height to 1024. After each last row the run state restarts for a new image.
module span_run_bottom_cutoff #(
    parameter int MAX_ROWS = 1024,
    parameter int COL_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [srbc_pkg::HEIGHT_W-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COL_BITS:0]              left_start,
    input  logic signed [COL_BITS:0]              left_end,
    input  logic signed [COL_BITS:0]              right_start,
    input  logic signed [COL_BITS:0]              right_end,
    input  logic                                  last_row,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  left_clear_enable,
    output logic [srbc_pkg::CLEAR_W-1:0]          left_clear_from,
    output logic                                  right_clear_enable,
    output logic [srbc_pkg::CLEAR_W-1:0]          right_clear_from
);

    localparam int RUN_W = $clog2(MAX_ROWS);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = ((ROW_W > srbc_pkg::HEIGHT_W) ? ROW_W : srbc_pkg::HEIGHT_W) + 1;

    logic [srbc_pkg::HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]              row_reg, row_next;

    logic                   take;
    logic                   active;
    logic [CMP_W-1:0]       row_plus_margin;
    srbc_pkg::lane_ctrl_t   ctrl;
    srbc_pkg::lane_result_t left_result;
    srbc_pkg::lane_result_t right_result;

    assign cfg_ready = 1'b1;
    assign in_ready  = !last_row || !out_valid || out_ready;
    assign take      = in_valid && in_ready;
    assign active    = (row_reg < ROW_W'(MAX_ROWS));

    // row < height - 24 as signed, rewritten without a negative operand.
    assign row_plus_margin = CMP_W'(row_reg) + CMP_W'(srbc_pkg::CUTOFF_MARGIN);

    always_comb
    begin
        ctrl.take      = take;
        ctrl.active    = active;
        ctrl.below_cut = (row_plus_margin < CMP_W'(height_reg));
        ctrl.restart   = last_row;
    end

    always_comb
    begin
        row_next = row_reg;
        if (last_row)
            row_next = '0;
        else if (active)
            row_next = row_reg + ROW_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= srbc_pkg::HEIGHT_RESET;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
                height_reg <= cfg_data;
            if (take)
                row_reg <= row_next;
        end
    end

    srbc_lane #(
        .COL_BITS (COL_BITS),
        .MAX_ROWS (MAX_ROWS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .row        (row_reg[RUN_W-1:0]),
        .span_start (left_start),
        .span_end   (left_end),
        .result     (left_result)
    );

    srbc_lane #(
        .COL_BITS (COL_BITS),
        .MAX_ROWS (MAX_ROWS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .row        (row_reg[RUN_W-1:0]),
        .span_start (right_start),
        .span_end   (right_end),
        .result     (right_result)
    );

    srbc_merge u_merge (
        .clk                (clk),
        .rst_n              (rst_n),
        .load               (take && last_row),
        .left_result        (left_result),
        .right_result       (right_result),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .left_clear_enable  (left_clear_enable),
        .left_clear_from    (left_clear_from),
        .right_clear_enable (right_clear_enable),
        .right_clear_from   (right_clear_from)
    );

endmodule

// ----- src/srbc_checker.sv -----
module srbc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          last_row,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          left_clear_enable,
    input logic [srbc_pkg::CLEAR_W-1:0]  left_clear_from,
    input logic                          right_clear_enable,
    input logic [srbc_pkg::CLEAR_W-1:0]  right_clear_from
);

    // A waiting report holds still until it transfers.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(left_clear_enable) &&
            $stable(left_clear_from) && $stable(right_clear_enable) &&
            $stable(right_clear_from));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("report changed while stalled");

    // Every last row produces a report in the next cycle.
    property p_last_reports;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_row) |=> out_valid;
    endproperty
    a_last_reports: assert property (p_last_reports) else $error("last row gave no report");

    // Ordinary rows never create a report.
    property p_no_spurious;
        @(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready && last_row)) |=> !out_valid;
    endproperty
    a_no_spurious: assert property (p_no_spurious) else $error("report without last row");

    // A side with fewer than two runs reports row zero.
    property p_disabled_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((left_clear_enable || (left_clear_from == '0)) &&
                       (right_clear_enable || (right_clear_from == '0)));
    endproperty
    a_disabled_zero: assert property (p_disabled_zero) else $error("clear row without enable");

    // Rows are only held off by a last row meeting a stalled report.
    property p_ready_reason;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && last_row);
    endproperty
    a_ready_reason: assert property (p_ready_reason) else $error("input stalled without cause");

endmodule

bind span_run_bottom_cutoff srbc_checker u_srbc_checker (.*);

// ----- test/span_run_bottom_cutoff_test.sv -----
module span_run_bottom_cutoff_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_BITS = 12;
    localparam int SPAN_W = COL_BITS + 1;
    localparam int COL_MAX = (1 << COL_BITS) - 1;
    localparam int ROW_LIMIT = 1024;
    localparam int SETTLE_CYCLES = 4;
    localparam int TARGET_ROWS = 1750;
    localparam int MAX_GAP = 14;

    typedef logic signed [SPAN_W-1:0] col_t;

    localparam col_t NO_COL = -1;

    typedef struct {
        col_t lo;
        col_t hi;
    } span_t;

    // Run bookkeeping for one side of the image.
    typedef struct {
        col_t       prev_start;
        col_t       prev_end;
        logic [1:0] runs;
        logic [9:0] first_end;
        logic [9:0] chosen_end;
        logic       chosen_cur;
        logic       have_chosen;
    } track_t;

    typedef struct packed {
        srbc_pkg::lane_result_t left;
        srbc_pkg::lane_result_t right;
    } report_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [srbc_pkg::HEIGHT_W-1:0] cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    col_t                          left_start;
    col_t                          left_end;
    col_t                          right_start;
    col_t                          right_end;
    logic                          last_row;
    logic                          out_valid;
    logic                          out_ready;
    logic                          left_clear_enable;
    logic [srbc_pkg::CLEAR_W-1:0]  left_clear_from;
    logic                          right_clear_enable;
    logic [srbc_pkg::CLEAR_W-1:0]  right_clear_from;

    track_t                        tracks[2];
    logic [10:0]                   row_num;
    logic [srbc_pkg::HEIGHT_W-1:0] height_model;
    report_t                       pending_reports[$];

    span_t prev_left;
    span_t prev_right;
    int    rows_sent = 0;
    int    mismatches = 0;
    int    sink_hold = 0;
    bit    source_gaps = 1'b1;
    bit    sink_gaps = 1'b1;

    span_run_bottom_cutoff #(
        .MAX_ROWS(ROW_LIMIT),
        .COL_BITS(COL_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .left_start(left_start),
        .left_end(left_end),
        .right_start(right_start),
        .right_end(right_end),
        .last_row(last_row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .left_clear_enable(left_clear_enable),
        .left_clear_from(left_clear_from),
        .right_clear_enable(right_clear_enable),
        .right_clear_from(right_clear_from)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("span_run_bottom_cutoff regression: fail");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic span_t mk_span(input int lo, input int hi);
        span_t s;
        s.lo = col_t'(lo);
        s.hi = col_t'(hi);
        return s;
    endfunction

    function automatic void restart_tracks();
        row_num = '0;
        for (int s = 0; s < 2; s++)
        begin
            tracks[s].prev_start = NO_COL;
            tracks[s].prev_end = NO_COL;
            tracks[s].runs = '0;
            tracks[s].first_end = '0;
            tracks[s].chosen_end = '0;
            tracks[s].chosen_cur = 1'b0;
            tracks[s].have_chosen = 1'b0;
        end
    endfunction

    function automatic track_t advance_track(input track_t t, input col_t st, input col_t en,
                                             input int row, input int cut);
        logic prev_ok;
        prev_ok = (t.prev_start >= 0) && (t.prev_end >= 0);
        if (st < 0 || en < 0)
        begin
            t.prev_start = NO_COL;
            t.prev_end = NO_COL;
        end
        else
        begin
            if (prev_ok && !(en < t.prev_start || st > t.prev_end))
            begin
                // Same run goes on; only the ends of runs still being tracked move.
                if (t.runs == srbc_pkg::RUN_CNT_ONE)
                    t.first_end = row[9:0];
                if (t.chosen_cur)
                    t.chosen_end = row[9:0];
            end
            else
            begin
                if (t.runs != srbc_pkg::RUN_CNT_MAX)
                    t.runs = t.runs + 2'd1;
                if (t.runs == srbc_pkg::RUN_CNT_ONE)
                    t.first_end = row[9:0];
                if (row < cut)
                begin
                    t.have_chosen = 1'b1;
                    t.chosen_cur = 1'b1;
                    t.chosen_end = row[9:0];
                end
                else
                    t.chosen_cur = 1'b0;
            end
            t.prev_start = st;
            t.prev_end = en;
        end
        return t;
    endfunction

    function automatic srbc_pkg::lane_result_t side_report(input track_t t);
        srbc_pkg::lane_result_t r;
        logic [9:0] e;
        r = '0;
        if (t.runs == srbc_pkg::RUN_CNT_MAX)
        begin
            e = t.have_chosen ? t.chosen_end : t.first_end;
            r.clear_enable = 1'b1;
            r.clear_from = {1'b0, e} + 11'd1;
        end
        return r;
    endfunction

    task automatic track_row(input span_t l, input span_t r, input logic last);
        int cut;
        report_t rep;
        cut = int'(height_model) - srbc_pkg::CUTOFF_MARGIN;
        if (row_num < ROW_LIMIT)
        begin
            tracks[0] = advance_track(tracks[0], l.lo, l.hi, int'(row_num), cut);
            tracks[1] = advance_track(tracks[1], r.lo, r.hi, int'(row_num), cut);
            row_num = row_num + 11'd1;
        end
        if (last)
        begin
            rep.left = side_report(tracks[0]);
            rep.right = side_report(tracks[1]);
            pending_reports.push_back(rep);
            restart_tracks();
        end
    endtask

    task automatic check_report();
        report_t want;
        if (pending_reports.size() == 0)
            flag_mismatch("report arrived with no image pending");
        else
        begin
            want = pending_reports.pop_front();
            if (left_clear_enable !== want.left.clear_enable)
                flag_mismatch($sformatf("left_clear_enable got %b want %b",
                                        left_clear_enable, want.left.clear_enable));
            if (left_clear_from !== want.left.clear_from)
                flag_mismatch($sformatf("left_clear_from got %0d want %0d",
                                        left_clear_from, want.left.clear_from));
            if (right_clear_enable !== want.right.clear_enable)
                flag_mismatch($sformatf("right_clear_enable got %b want %b",
                                        right_clear_enable, want.right.clear_enable));
            if (right_clear_from !== want.right.clear_from)
                flag_mismatch($sformatf("right_clear_from got %0d want %0d",
                                        right_clear_from, want.right.clear_from));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_report();
    end

    // Receiver: random ready gaps, plus a long hold-off when a test asks for one.
    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            else
            begin
                gap = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
                do
                    @(posedge clk);
                while (!(out_valid && out_ready) && sink_hold == 0);
            end
        end
    end

    task automatic send_row(input span_t l, input span_t r, input logic last);
        int gap;
        gap = source_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        left_start <= l.lo;
        left_end <= l.hi;
        right_start <= r.lo;
        right_end <= r.hi;
        last_row <= last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        track_row(l, r, last);
        prev_left = l;
        prev_right = r;
        rows_sent++;
    endtask

    task automatic write_height(input logic [srbc_pkg::HEIGHT_W-1:0] h);
        cfg_data <= h;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        height_model = h;
    endtask

    // Stops offering rows and waits until every report is back and the block is quiet.
    task automatic wait_reports_done();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly drifts the previous span so runs grow long; the rest breaks them up.
    function automatic span_t pick_span(input span_t prev);
        span_t s;
        int pick;
        int a;
        int b;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            case ($urandom_range(0, 2))
                0: s = mk_span(-1, -1);
                1: s = mk_span(-1, $urandom_range(0, COL_MAX));
                default: s = mk_span($urandom_range(0, COL_MAX), -1);
            endcase
        end
        else if (pick < 12)
        begin
            case ($urandom_range(0, 2))
                0: s = mk_span(0, 0);
                1: s = mk_span(COL_MAX, COL_MAX);
                default: s = mk_span(0, COL_MAX);
            endcase
        end
        else if (pick < 24 || prev.lo < 0 || prev.hi < 0)
        begin
            a = $urandom_range(0, COL_MAX);
            b = a + int'($urandom_range(0, 400));
            s = mk_span(a, (b > COL_MAX) ? COL_MAX : b);
        end
        else
        begin
            a = int'(prev.lo) + int'($urandom_range(0, 60)) - 30;
            b = int'(prev.hi) + int'($urandom_range(0, 60)) - 30;
            a = (a < 0) ? 0 : ((a > COL_MAX) ? COL_MAX : a);
            b = (b < 0) ? 0 : ((b > COL_MAX) ? COL_MAX : b);
            s = mk_span(a, (b < a) ? a : b);
        end
        return s;
    endfunction

    task automatic send_image(input int rows);
        span_t l;
        span_t r;
        for (int i = 0; i < rows; i++)
        begin
            l = pick_span(prev_left);
            r = pick_span(prev_right);
            send_row(l, r, i == rows - 1);
        end
    endtask

    task automatic test_single_row_images();
        send_row(mk_span(-1, -1), mk_span(-1, -1), 1'b1);
        send_row(mk_span(0, COL_MAX), mk_span(7, 7), 1'b1);
        wait_reports_done();
    endtask

    task automatic test_span_extremes();
        send_row(mk_span(0, COL_MAX), mk_span(-1, COL_MAX), 1'b0);
        send_row(mk_span(0, 0), mk_span(5, -1), 1'b0);
        send_row(mk_span(COL_MAX, COL_MAX), mk_span(COL_MAX, COL_MAX), 1'b0);
        send_row(mk_span(-1, -1), mk_span(0, 0), 1'b1);
        wait_reports_done();
    endtask

    task automatic test_overlap_edges();
        // Left: touching ends still join the run, one column short starts a new one.
        // Right: one column past the end, then the same span again after an empty row.
        send_row(mk_span(100, 200), mk_span(500, 600), 1'b0);
        send_row(mk_span(50, 100), mk_span(601, 700), 1'b0);
        send_row(mk_span(100, 300), mk_span(-1, -1), 1'b0);
        send_row(mk_span(10, 99), mk_span(601, 700), 1'b0);
        send_row(mk_span(10, 99), mk_span(650, 650), 1'b1);
        wait_reports_done();
    endtask

    task automatic test_cutoff_heights();
        logic [srbc_pkg::HEIGHT_W-1:0] heights[3];
        heights[0] = '0;
        heights[1] = 11'(srbc_pkg::CUTOFF_MARGIN + 1);
        heights[2] = srbc_pkg::HEIGHT_RESET;
        for (int k = 0; k < 3; k++)
        begin
            write_height(heights[k]);
            send_row(mk_span(10, 20), mk_span(2000, 2100), 1'b0);
            send_row(mk_span(30, 40), mk_span(2000, 2100), 1'b0);
            send_row(mk_span(-1, -1), mk_span(2050, 2060), 1'b0);
            send_row(mk_span(30, 40), mk_span(2000, 2000), 1'b1);
            wait_reports_done();
        end
    endtask

    task automatic test_row_limit();
        span_t l;
        span_t r;
        write_height(srbc_pkg::HEIGHT_RESET);
        // The long left run reaches the last tracked row; rows past the limit
        // would start new runs on both sides if they were counted.
        for (int i = 0; i < ROW_LIMIT + 2; i++)
        begin
            if (i < 10)
                l = mk_span(100, 200);
            else if (i == 10)
                l = mk_span(-1, -1);
            else if (i < ROW_LIMIT)
                l = mk_span(300, 400);
            else
                l = mk_span(3000, 3100);
            r = (i % 2 == 0) ? mk_span(0, 10) : mk_span(20, 30);
            send_row(l, r, i == ROW_LIMIT + 1);
        end
        wait_reports_done();
    endtask

    task automatic test_output_stall();
        source_gaps = 1'b0;
        sink_hold = 300;
        repeat (6) send_image(2);
        wait_reports_done();
        source_gaps = 1'b1;
    endtask

    task automatic test_paced_images();
        repeat (3)
        begin
            send_image($urandom_range(1, 8));
            wait_reports_done();
        end
    endtask

    task automatic test_random_images();
        logic [srbc_pkg::HEIGHT_W-1:0] h;
        while (rows_sent < TARGET_ROWS)
        begin
            case ($urandom_range(0, 7))
                0: h = '0;
                1: h = 11'(srbc_pkg::CUTOFF_MARGIN);
                2: h = srbc_pkg::HEIGHT_RESET;
                3: h = 11'($urandom_range(0, 1024));
                default: h = 11'(srbc_pkg::CUTOFF_MARGIN + $urandom_range(1, 30));
            endcase
            write_height(h);
            source_gaps = ($urandom_range(0, 2) != 0);
            sink_gaps = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(2, 6)) send_image($urandom_range(1, 30));
            wait_reports_done();
        end
        source_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        left_start = NO_COL;
        left_end = NO_COL;
        right_start = NO_COL;
        right_end = NO_COL;
        last_row = 1'b0;
        prev_left = mk_span(-1, -1);
        prev_right = mk_span(-1, -1);
        height_model = srbc_pkg::HEIGHT_RESET;
        restart_tracks();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_row_images();
        test_span_extremes();
        test_overlap_edges();
        test_cutoff_heights();
        test_row_limit();
        test_output_stall();
        test_paced_images();
        test_random_images();

        if (pending_reports.size() != 0)
            flag_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
        if (mismatches == 0)
            $display("span_run_bottom_cutoff regression: pass");
        else
            $display("span_run_bottom_cutoff regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/srbc_pkg.sv
src/srbc_lane.sv
src/srbc_merge.sv
src/span_run_bottom_cutoff.sv
src/srbc_checker.sv
test/span_run_bottom_cutoff_test.sv
